// File: rtl/gai_pkg.sv
`timescale 1ns / 1ps
// gai_pkg: shared constants, codes and types of the gyro angle integrator.
// Used by gai_ctrl, gai_datapath and gyro_angle_integrator; depends on nothing.
package gai_pkg;

   // Calibration length and accumulator width
   localparam int CAL_SAMPLES = 100;
   localparam int ACC_WIDTH   = 40;

   // Field widths
   localparam int RATE_W      = 16;
   localparam int GAIN_W      = 24;
   localparam int WEIGHT_W    = 9;
   localparam int LIMIT_W     = 15;
   localparam int ANGLE_W     = 32;
   localparam int FRAC_W      = 16;
   localparam int KIND_W      = 2;
   localparam int CAL_ACC_W   = 24;
   localparam int CAL_CNT_W   = 7;

   // Fixed-point scaling
   localparam int INC_SHIFT   = 8;
   localparam int BLEND_SHIFT = 8;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << BLEND_SHIFT);

   // Stream and register port widths
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 104;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   // Register reset values
   localparam logic [GAIN_W-1:0]   RATE_GAIN_RST      = 24'd5872;
   localparam logic [WEIGHT_W-1:0] YAW_BLEND_RST      = 9'd205;
   localparam logic [WEIGHT_W-1:0] PITCH_BLEND_RST    = 9'd179;
   localparam logic [LIMIT_W-1:0]  YAW_LIMIT_RST      = 15'd360;
   localparam logic [LIMIT_W-1:0]  PITCH_LIMIT_RST    = 15'd40;
   localparam logic [LIMIT_W-1:0]  RAMP_THRESHOLD_RST = 15'd5;

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE    = 2'd0,
      KIND_CAL       = 2'd1,
      KIND_CLR_YAW   = 2'd2,
      KIND_CLR_PITCH = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_RATE_GAIN      = 3'd0,
      REG_YAW_BLEND      = 3'd1,
      REG_PITCH_BLEND    = 3'd2,
      REG_YAW_LIMIT      = 3'd3,
      REG_PITCH_LIMIT    = 3'd4,
      REG_RAMP_THRESHOLD = 3'd5
   } reg_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_UPD,
      ST_DIV,
      ST_BIAS,
      ST_BLEND,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   rate_gain;
      logic [WEIGHT_W-1:0] yaw_blend;
      logic [WEIGHT_W-1:0] pitch_blend;
      logic [LIMIT_W-1:0]  yaw_limit;
      logic [LIMIT_W-1:0]  pitch_limit;
      logic [LIMIT_W-1:0]  ramp_threshold;
   } cfg_type;

   // Controller to datapath: one step enable per cycle
   typedef struct packed {
      logic load;
      logic mul;
      logic upd;
      logic div;
      logic bias;
      logic blend;
      logic sum;
      logic out;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic cal_done;
      logic out_free;
   } status_type;

endpackage

// File: rtl/gai_ctrl.sv
`timescale 1ns / 1ps
// gai_ctrl: sequencer that steps one request through the datapath.
// Depends on gai_pkg.
module gai_ctrl
   import gai_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) state_in = ST_MUL;
         end
         ST_MUL:   state_in = ST_UPD;
         ST_UPD: begin
            state_in = status.cal_done ? ST_DIV : ST_BLEND;
         end
         ST_DIV:   state_in = ST_BIAS;
         ST_BIAS:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_SUM;
         ST_SUM:   state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_MUL:   cmd.mul   = 1'b1;
         ST_UPD:   cmd.upd   = 1'b1;
         ST_DIV:   cmd.div   = 1'b1;
         ST_BIAS:  cmd.bias  = 1'b1;
         ST_BLEND: cmd.blend = 1'b1;
         ST_SUM:   cmd.sum   = 1'b1;
         ST_OUT:   cmd.out   = status.out_free;
         default:  cmd       = '0;
      endcase
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> !in_ready)
      else $error("request taken while another is in progress");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && !status.out_free |=> state_ff == ST_OUT)
      else $error("result step left while output slot still full");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath step enabled");

endmodule

// File: rtl/gai_datapath.sv
`timescale 1ns / 1ps
// gai_datapath: bias, scaling, saturating accumulators, blend, clamp and result register.
// Depends on gai_pkg; steered by gai_ctrl.
module gai_datapath
   import gai_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  cmd_type                   cmd,
   output status_type                status,
   input  kind_type                  req_kind,
   input  logic signed [RATE_W-1:0]  req_rate_pitch,
   input  logic signed [RATE_W-1:0]  req_rate_yaw,
   input  logic                      req_ramp_idle,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [ANGLE_W-1:0] rsp_yaw_angle,
   output logic signed [ANGLE_W-1:0] rsp_pitch_angle,
   output logic signed [ANGLE_W-1:0] rsp_yaw_step,
   output logic                      rsp_ramp_enter,
   output logic                      rsp_bias_ready
);

   localparam int DIFF_W      = RATE_W + 1;
   localparam int PROD_W      = DIFF_W + GAIN_W + 1;
   localparam int INC_W       = PROD_W - INC_SHIFT;
   localparam int SUM_W       = ((ACC_WIDTH > INC_W) ? ACC_WIDTH : INC_W) + 1;
   localparam int BPROD_W     = ACC_WIDTH + WEIGHT_W + 1;
   localparam int BSUM_W      = BPROD_W + 1;
   // Reciprocal is exact for magnitudes below 2^(CAL_ACC_W-1) and counts below 2^CAL_CNT_W
   localparam int RECIP_SHIFT = CAL_ACC_W - 1 + CAL_CNT_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int DPROD_W     = CAL_ACC_W + RECIP_W;
   localparam logic [RECIP_W-1:0] CAL_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [ANGLE_W-1:0]   ANG_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [ANGLE_W-1:0]   ANG_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(ACC_MAX)) return ACC_MAX;
      if (v < SUM_W'(ACC_MIN)) return ACC_MIN;
      return ACC_WIDTH'(v);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [INC_W-1:0] v);
      if (v > INC_W'(ANG_MAX)) return ANG_MAX;
      if (v < INC_W'(ANG_MIN)) return ANG_MIN;
      return ANGLE_W'(v);
   endfunction

   function automatic logic signed [ANGLE_W-1:0] clamp_sym(
      input logic signed [ACC_WIDTH-1:0] v,
      input logic [LIMIT_W-1:0]          limit
   );
      logic signed [ACC_WIDTH-1:0] lim;
      lim = $signed(ACC_WIDTH'({limit, {FRAC_W{1'b0}}}));
      if (v > lim)  return ANGLE_W'(lim);
      if (v < -lim) return ANGLE_W'(-lim);
      return ANGLE_W'(v);
   endfunction

   // Control state (reset)
   logic signed [ACC_WIDTH-1:0] yaw_sum_ff, yaw_sum_in, yaw_prev_ff, yaw_prev_in;
   logic signed [ACC_WIDTH-1:0] pitch_sum_ff, pitch_sum_in, pitch_prev_ff, pitch_prev_in;
   logic signed [RATE_W-1:0]    bias_y_ff, bias_y_in, bias_p_ff, bias_p_in;
   logic signed [CAL_ACC_W-1:0] cal_acc_y_ff, cal_acc_y_in, cal_acc_p_ff, cal_acc_p_in;
   logic [CAL_CNT_W-1:0]        cal_count_ff, cal_count_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Working and result registers (no reset)
   kind_type                    kind_ff, kind_in;
   logic signed [RATE_W-1:0]    rate_y_ff, rate_y_in, rate_p_ff, rate_p_in;
   logic                        idle_ff, idle_in;
   logic signed [PROD_W-1:0]    prod_y_ff, prod_y_in, prod_p_ff, prod_p_in;
   logic signed [ANGLE_W-1:0]   ystep_ff, ystep_in;
   logic [DPROD_W-1:0]          dprod_y_ff, dprod_y_in, dprod_p_ff, dprod_p_in;
   logic                        ready_flag_ff, ready_flag_in;
   logic signed [BPROD_W-1:0]   bcur_y_ff, bcur_y_in, bprev_y_ff, bprev_y_in;
   logic signed [BPROD_W-1:0]   bcur_p_ff, bcur_p_in, bprev_p_ff, bprev_p_in;
   logic signed [ACC_WIDTH-1:0] blend_y_ff, blend_y_in, blend_p_ff, blend_p_in;
   logic signed [ANGLE_W-1:0]   rsp_yaw_ff, rsp_yaw_in, rsp_pitch_ff, rsp_pitch_in;
   logic signed [ANGLE_W-1:0]   rsp_step_ff, rsp_step_in;
   logic                        rsp_ramp_ff, rsp_ramp_in, rsp_bias_ff, rsp_bias_in;

   // Combinational intermediates
   logic signed [DIFF_W-1:0]    diff_y, diff_p;
   logic signed [GAIN_W:0]      gain_s;
   logic signed [INC_W-1:0]     inc_y, inc_p;
   logic [CAL_CNT_W-1:0]        cnt_next;
   logic                        cal_last;
   logic [CAL_ACC_W-1:0]        mag_y, mag_p;
   logic [RATE_W-1:0]           quo_y, quo_p;
   logic [WEIGHT_W-1:0]         wt_y, wc_y, wt_p, wc_p;
   logic signed [BSUM_W-1:0]    bsum_y, bsum_p;
   logic signed [ANGLE_W-1:0]   clamp_y, clamp_p;
   logic signed [ANGLE_W-1:0]   thr_s;

   // Bias removal and gain
   assign diff_y = DIFF_W'(rate_y_ff) - DIFF_W'(bias_y_ff);
   assign diff_p = DIFF_W'(rate_p_ff) - DIFF_W'(bias_p_ff);
   assign gain_s = $signed({1'b0, cfg.rate_gain});
   assign inc_y  = INC_W'(prod_y_ff >>> INC_SHIFT);
   assign inc_p  = INC_W'(prod_p_ff >>> INC_SHIFT);

   // Calibration count and bias division by reciprocal multiply
   assign cnt_next = cal_count_ff + CAL_CNT_W'(1);
   assign cal_last = cnt_next >= CAL_CNT_W'(CAL_SAMPLES);
   assign mag_y    = cal_acc_y_ff[CAL_ACC_W-1] ? -cal_acc_y_ff : cal_acc_y_ff;
   assign mag_p    = cal_acc_p_ff[CAL_ACC_W-1] ? -cal_acc_p_ff : cal_acc_p_ff;
   assign quo_y    = dprod_y_ff[RECIP_SHIFT +: RATE_W];
   assign quo_p    = dprod_p_ff[RECIP_SHIFT +: RATE_W];

   // Blend weights, saturated at one
   assign wt_y   = (cfg.yaw_blend > WEIGHT_ONE) ? WEIGHT_ONE : cfg.yaw_blend;
   assign wc_y   = WEIGHT_ONE - wt_y;
   assign wt_p   = (cfg.pitch_blend > WEIGHT_ONE) ? WEIGHT_ONE : cfg.pitch_blend;
   assign wc_p   = WEIGHT_ONE - wt_p;
   assign bsum_y = BSUM_W'(bcur_y_ff) + BSUM_W'(bprev_y_ff);
   assign bsum_p = BSUM_W'(bcur_p_ff) + BSUM_W'(bprev_p_ff);

   // Clamp and ramp test
   assign clamp_y = clamp_sym(blend_y_ff, cfg.yaw_limit);
   assign clamp_p = clamp_sym(blend_p_ff, cfg.pitch_limit);
   assign thr_s   = $signed(ANGLE_W'({cfg.ramp_threshold, {FRAC_W{1'b0}}}));

   always_comb begin
      yaw_sum_in    = yaw_sum_ff;
      yaw_prev_in   = yaw_prev_ff;
      pitch_sum_in  = pitch_sum_ff;
      pitch_prev_in = pitch_prev_ff;
      bias_y_in     = bias_y_ff;
      bias_p_in     = bias_p_ff;
      cal_acc_y_in  = cal_acc_y_ff;
      cal_acc_p_in  = cal_acc_p_ff;
      cal_count_in  = cal_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      rate_y_in     = rate_y_ff;
      rate_p_in     = rate_p_ff;
      idle_in       = idle_ff;
      prod_y_in     = prod_y_ff;
      prod_p_in     = prod_p_ff;
      ystep_in      = ystep_ff;
      dprod_y_in    = dprod_y_ff;
      dprod_p_in    = dprod_p_ff;
      ready_flag_in = ready_flag_ff;
      bcur_y_in     = bcur_y_ff;
      bprev_y_in    = bprev_y_ff;
      bcur_p_in     = bcur_p_ff;
      bprev_p_in    = bprev_p_ff;
      blend_y_in    = blend_y_ff;
      blend_p_in    = blend_p_ff;
      rsp_yaw_in    = rsp_yaw_ff;
      rsp_pitch_in  = rsp_pitch_ff;
      rsp_step_in   = rsp_step_ff;
      rsp_ramp_in   = rsp_ramp_ff;
      rsp_bias_in   = rsp_bias_ff;

      if (cmd.load) begin
         kind_in       = req_kind;
         rate_y_in     = req_rate_yaw;
         rate_p_in     = req_rate_pitch;
         idle_in       = req_ramp_idle;
         ready_flag_in = 1'b0;
      end

      if (cmd.mul) begin
         prod_y_in = PROD_W'(diff_y) * PROD_W'(gain_s);
         prod_p_in = PROD_W'(diff_p) * PROD_W'(gain_s);
      end

      if (cmd.upd) begin
         ystep_in = '0;
         case (kind_ff)
            KIND_SAMPLE: begin
               ystep_in      = sat_angle(inc_y);
               yaw_prev_in   = yaw_sum_ff;
               yaw_sum_in    = sat_acc(SUM_W'(yaw_sum_ff) + SUM_W'(inc_y));
               pitch_prev_in = pitch_sum_ff;
               pitch_sum_in  = sat_acc(SUM_W'(pitch_sum_ff) + SUM_W'(inc_p));
            end
            KIND_CAL: begin
               cal_acc_y_in = cal_acc_y_ff + CAL_ACC_W'(rate_y_ff);
               cal_acc_p_in = cal_acc_p_ff + CAL_ACC_W'(rate_p_ff);
               cal_count_in = cal_last ? '0 : cnt_next;
            end
            KIND_CLR_YAW: begin
               yaw_sum_in  = '0;
               yaw_prev_in = '0;
            end
            default: begin
               pitch_sum_in  = '0;
               pitch_prev_in = '0;
            end
         endcase
      end

      if (cmd.div) begin
         dprod_y_in = DPROD_W'(mag_y) * DPROD_W'(CAL_RECIP);
         dprod_p_in = DPROD_W'(mag_p) * DPROD_W'(CAL_RECIP);
      end

      if (cmd.bias) begin
         bias_y_in     = cal_acc_y_ff[CAL_ACC_W-1] ? $signed(-quo_y) : $signed(quo_y);
         bias_p_in     = cal_acc_p_ff[CAL_ACC_W-1] ? $signed(-quo_p) : $signed(quo_p);
         cal_acc_y_in  = '0;
         cal_acc_p_in  = '0;
         ready_flag_in = 1'b1;
      end

      if (cmd.blend) begin
         bcur_y_in  = BPROD_W'(yaw_sum_ff) * BPROD_W'($signed({1'b0, wt_y}));
         bprev_y_in = BPROD_W'(yaw_prev_ff) * BPROD_W'($signed({1'b0, wc_y}));
         bcur_p_in  = BPROD_W'(pitch_sum_ff) * BPROD_W'($signed({1'b0, wt_p}));
         bprev_p_in = BPROD_W'(pitch_prev_ff) * BPROD_W'($signed({1'b0, wc_p}));
      end

      if (cmd.sum) begin
         blend_y_in = ACC_WIDTH'(bsum_y >>> BLEND_SHIFT);
         blend_p_in = ACC_WIDTH'(bsum_p >>> BLEND_SHIFT);
      end

      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out) begin
         rsp_valid_in = 1'b1;
         rsp_yaw_in   = -clamp_y;
         rsp_pitch_in = clamp_p;
         rsp_step_in  = ystep_ff;
         rsp_ramp_in  = (kind_ff == KIND_SAMPLE) && idle_ff && (clamp_p >= thr_s);
         rsp_bias_in  = ready_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_sum_ff    <= '0;
         yaw_prev_ff   <= '0;
         pitch_sum_ff  <= '0;
         pitch_prev_ff <= '0;
         bias_y_ff     <= '0;
         bias_p_ff     <= '0;
         cal_acc_y_ff  <= '0;
         cal_acc_p_ff  <= '0;
         cal_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         yaw_sum_ff    <= yaw_sum_in;
         yaw_prev_ff   <= yaw_prev_in;
         pitch_sum_ff  <= pitch_sum_in;
         pitch_prev_ff <= pitch_prev_in;
         bias_y_ff     <= bias_y_in;
         bias_p_ff     <= bias_p_in;
         cal_acc_y_ff  <= cal_acc_y_in;
         cal_acc_p_ff  <= cal_acc_p_in;
         cal_count_ff  <= cal_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      rate_y_ff     <= rate_y_in;
      rate_p_ff     <= rate_p_in;
      idle_ff       <= idle_in;
      prod_y_ff     <= prod_y_in;
      prod_p_ff     <= prod_p_in;
      ystep_ff      <= ystep_in;
      dprod_y_ff    <= dprod_y_in;
      dprod_p_ff    <= dprod_p_in;
      ready_flag_ff <= ready_flag_in;
      bcur_y_ff     <= bcur_y_in;
      bprev_y_ff    <= bprev_y_in;
      bcur_p_ff     <= bcur_p_in;
      bprev_p_ff    <= bprev_p_in;
      blend_y_ff    <= blend_y_in;
      blend_p_ff    <= blend_p_in;
      rsp_yaw_ff    <= rsp_yaw_in;
      rsp_pitch_ff  <= rsp_pitch_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_ramp_ff   <= rsp_ramp_in;
      rsp_bias_ff   <= rsp_bias_in;
   end

   assign status.cal_done = (kind_ff == KIND_CAL) && cal_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_yaw_angle   = rsp_yaw_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_yaw_step    = rsp_step_ff;
   assign rsp_ramp_enter  = rsp_ramp_ff;
   assign rsp_bias_ready  = rsp_bias_ff;

   a_cal_count_range: assert property (@(posedge clock) disable iff (reset)
      cal_count_ff < CAL_CNT_W'(CAL_SAMPLES))
      else $error("calibration count past its end");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ramp_ff |-> !rsp_bias_ff)
      else $error("ramp entry on a calibration result");

   a_ramp_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ramp_ff |-> !rsp_pitch_ff[ANGLE_W-1])
      else $error("ramp entry with negative pitch");

endmodule

// File: rtl/gyro_angle_integrator.sv
`timescale 1ns / 1ps
// The sequencer walks each request through multiply, accumulate, blend and clamp steps;
// the calibration request that completes the bias takes two more steps for the bias division.
// A new request is taken only after the previous result has entered the result register;
// the output step waits while that register still holds a result not yet taken.
// Reset (synchronous, active high): zero accumulators, biases and calibration state,
// restore register defaults, drop any pending result.
//
// gyro_angle_integrator: top level with register file, sequencer and datapath.
// Depends on gai_pkg, gai_ctrl and gai_datapath.
module gyro_angle_integrator
   import gai_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tdata: rate_pitch[15:0], rate_yaw[31:16], ramp_idle[32], zero[39:33]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // tdata: yaw_angle[31:0], pitch_angle[63:32], yaw_step[95:64],
   //        ramp_enter[96], bias_ready[97], zero[103:98]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         csr_wr;
   reg_addr_type reg_sel;

   cmd_type      cmd;
   status_type   status;

   logic signed [ANGLE_W-1:0] yaw_angle;
   logic signed [ANGLE_W-1:0] pitch_angle;
   logic signed [ANGLE_W-1:0] yaw_step;
   logic                      ramp_enter;
   logic                      bias_ready;

   // Register file: no wait states, word addressed
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = reg_addr_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_sel)
            REG_RATE_GAIN:      cfg_in.rate_gain      = csr_pwdata[GAIN_W-1:0];
            REG_YAW_BLEND:      cfg_in.yaw_blend      = csr_pwdata[WEIGHT_W-1:0];
            REG_PITCH_BLEND:    cfg_in.pitch_blend    = csr_pwdata[WEIGHT_W-1:0];
            REG_YAW_LIMIT:      cfg_in.yaw_limit      = csr_pwdata[LIMIT_W-1:0];
            REG_PITCH_LIMIT:    cfg_in.pitch_limit    = csr_pwdata[LIMIT_W-1:0];
            REG_RAMP_THRESHOLD: cfg_in.ramp_threshold = csr_pwdata[LIMIT_W-1:0];
            default:            cfg_in = cfg_ff;   // unmapped address: drop the write
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_gain      <= RATE_GAIN_RST;
         cfg_ff.yaw_blend      <= YAW_BLEND_RST;
         cfg_ff.pitch_blend    <= PITCH_BLEND_RST;
         cfg_ff.yaw_limit      <= YAW_LIMIT_RST;
         cfg_ff.pitch_limit    <= PITCH_LIMIT_RST;
         cfg_ff.ramp_threshold <= RAMP_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register, zero for unmapped addresses
   always_comb begin
      csr_prdata = '0;
      unique case (reg_sel)
         REG_RATE_GAIN:      csr_prdata = CSR_DATA_W'(cfg_ff.rate_gain);
         REG_YAW_BLEND:      csr_prdata = CSR_DATA_W'(cfg_ff.yaw_blend);
         REG_PITCH_BLEND:    csr_prdata = CSR_DATA_W'(cfg_ff.pitch_blend);
         REG_YAW_LIMIT:      csr_prdata = CSR_DATA_W'(cfg_ff.yaw_limit);
         REG_PITCH_LIMIT:    csr_prdata = CSR_DATA_W'(cfg_ff.pitch_limit);
         REG_RAMP_THRESHOLD: csr_prdata = CSR_DATA_W'(cfg_ff.ramp_threshold);
         default:            csr_prdata = '0;
      endcase
   end

   // Sequencer: takes a request only when the previous one has reached the result register
   gai_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath: holds the accumulators and the result register, which lets
   // a new request in while a finished result still waits downstream
   gai_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd             (cmd),
      .status          (status),
      .req_kind        (kind_type'(req_tuser)),
      .req_rate_pitch  ($signed(req_tdata[RATE_W-1:0])),
      .req_rate_yaw    ($signed(req_tdata[2*RATE_W-1:RATE_W])),
      .req_ramp_idle   (req_tdata[2*RATE_W]),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_yaw_angle   (yaw_angle),
      .rsp_pitch_angle (pitch_angle),
      .rsp_yaw_step    (yaw_step),
      .rsp_ramp_enter  (ramp_enter),
      .rsp_bias_ready  (bias_ready)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = RSP_DATA_W'({bias_ready, ramp_enter, yaw_step, pitch_angle, yaw_angle});

endmodule
